@@ hw/rtl/vcph_pkg.sv @@
// Shared types and codes of the voxel cube pattern histogram.
package vcph_pkg;

   localparam int unsigned ModeWidth   = 2;
   localparam int unsigned ColumnWidth = 4;
   localparam int unsigned BinWidth    = 8;
   localparam int unsigned BinCount    = 256;
   localparam int unsigned OutWidth    = 32;

   typedef enum logic [ModeWidth-1:0] {
      MODE_PUSH  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   typedef logic [BinWidth-1:0]    bin_type;
   typedef logic [ColumnWidth-1:0] column_type;

endpackage

@@ hw/rtl/vcph_if.sv @@
// Request and response channel interfaces of the voxel cube pattern histogram.
interface vcph_req_if import vcph_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] column_bits;
   logic       row_start;
   logic [7:0] bin_number;

   modport source (output valid, output mode, output column_bits, output row_start,
                   output bin_number, input ready);
   modport sink   (input valid, input mode, input column_bits, input row_start,
                   input bin_number, output ready);
endinterface

interface vcph_rsp_if import vcph_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] bin_count;
   logic [7:0]  bin_echo;

   modport source (output valid, output bin_count, output bin_echo, input ready);
   modport sink   (input valid, input bin_count, input bin_echo, output ready);
endinterface

@@ hw/rtl/voxel_cube_pattern_histogram.sv @@
// Binary 2x2x2 voxel pattern histogram: a column stream in, single-bin reads out.
//
// Each push request carries one column of four binary voxels (two rows in each
// of two planes). The column is joined with the previous column of the same row
// into an 8-bit cube pattern, previous column in the low nibble and new column
// in the high nibble, and that bin of a 256-entry histogram is incremented;
// counters wrap at 2^COUNT_WIDTH. A column flagged as row start, and the first
// column after reset, only become the previous column. A read request returns
// one bin and its number; a read-and-clear request also zeroes the bin. Requests
// of the unused mode are taken and ignored. Pushes return nothing. The block
// takes one request per clock: the histogram is a single synchronous memory,
// read on the cycle a request is accepted and written back from the update
// stage, with the write data forwarded when the next request hits the same bin.
// A response is registered after the update stage and held there; a request is
// still accepted while a response waits, as long as the stage behind the memory
// does not itself hold a read. Per-bin valid flags, cleared at reset, make the
// histogram read as zero from the first cycle: no clearing pass.
module voxel_cube_pattern_histogram
   import vcph_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   vcph_req_if.sink   req_channel,
   vcph_rsp_if.source rsp_channel
);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Histogram store and its valid flags
   count_type             hist_mem [BinCount];
   logic [BinCount-1:0]   bin_valid_ff;

   // Column history
   column_type            prev_column_ff;
   logic                  have_prev_ff;

   // Read stage
   count_type             rd_data_ff;
   logic                  rd_valid_ff;
   logic                  fwd_ff;
   count_type             fwd_data_ff;

   // Update stage
   logic                  s1_valid_ff;
   mode_type              s1_op_ff;
   bin_type               s1_addr_ff;

   // Output register
   logic                  rsp_valid_ff;
   logic [OutWidth-1:0]   rsp_count_ff;
   bin_type               rsp_echo_ff;

   mode_type              req_mode;
   column_type            req_column;
   logic                  req_accept;
   logic                  req_counts;
   logic                  s1_in;
   bin_type               req_addr;
   logic                  s1_go;
   logic                  s1_reads;
   logic                  s1_write;
   count_type             s1_old;
   count_type             s1_wdata;
   logic                  rsp_load;
   logic [OutWidth-1:0]   s1_out;

   assign req_mode   = mode_type'(req_channel.mode);
   assign req_column = req_channel.column_bits;

   // The update stage moves on unless it holds a read that the full output
   // register cannot take.
   assign s1_reads = (s1_op_ff == MODE_READ) || (s1_op_ff == MODE_CLEAR);
   assign s1_go    = !s1_valid_ff || !s1_reads || !rsp_valid_ff || rsp_channel.ready;

   assign req_channel.ready = s1_go;
   assign req_accept        = req_channel.valid && s1_go;

   // A push counts only with a previous column in the same row.
   assign req_counts = (req_mode == MODE_PUSH) && !req_channel.row_start && have_prev_ff;
   assign s1_in      = req_accept &&
                       (req_counts || (req_mode == MODE_READ) || (req_mode == MODE_CLEAR));
   assign req_addr   = (req_mode == MODE_PUSH) ? {req_column, prev_column_ff}
                                               : req_channel.bin_number;

   // Old count: forwarded write-back, else memory, else zero for an untouched bin.
   always_comb begin
      if (fwd_ff) begin
         s1_old = fwd_data_ff;
      end else if (rd_valid_ff) begin
         s1_old = rd_data_ff;
      end else begin
         s1_old = '0;
      end
   end

   always_comb begin
      case (s1_op_ff)
         MODE_PUSH:  s1_wdata = s1_old + count_type'(1);
         MODE_CLEAR: s1_wdata = '0;
         default:    s1_wdata = s1_old;
      endcase
   end

   assign s1_write = s1_valid_ff && s1_go &&
                     ((s1_op_ff == MODE_PUSH) || (s1_op_ff == MODE_CLEAR));
   assign rsp_load = s1_valid_ff && s1_go && s1_reads;

   // Present the low bits of a wide counter, zero-extend a narrow one.
   generate
      if (COUNT_WIDTH >= OutWidth) begin : g_out_trunc
         assign s1_out = s1_old[OutWidth-1:0];
      end else begin : g_out_ext
         assign s1_out = {{(OutWidth-COUNT_WIDTH){1'b0}}, s1_old};
      end
   endgenerate

   // Memory: read on accept, write back from the update stage.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= hist_mem[req_addr];
      end
      if (s1_write) begin
         hist_mem[s1_addr_ff] <= s1_wdata;
      end
   end

   // Payload of the read and update stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_valid_ff <= bin_valid_ff[req_addr];
         fwd_data_ff <= s1_wdata;
         s1_op_ff    <= req_mode;
         s1_addr_ff  <= req_addr;
      end
      if (rsp_load) begin
         rsp_count_ff <= s1_out;
         rsp_echo_ff  <= s1_addr_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff   <= '0;
         prev_column_ff <= '0;
         have_prev_ff   <= 1'b0;
         fwd_ff         <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (s1_write) begin
            bin_valid_ff[s1_addr_ff] <= 1'b1;
         end
         if (req_accept && (req_mode == MODE_PUSH)) begin
            prev_column_ff <= req_column;
            have_prev_ff   <= 1'b1;
         end
         if (req_accept) begin
            // Forward when the write-back lands on the bin just read.
            fwd_ff <= s1_write && (s1_addr_ff == req_addr);
         end
         if (s1_go) begin
            s1_valid_ff <= s1_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_channel.valid     = rsp_valid_ff;
   assign rsp_channel.bin_count = rsp_count_ff;
   assign rsp_channel.bin_echo  = rsp_echo_ff;

   // Hit on the bin being written back must select forwarded data.
   a_forward: assert property (@(posedge clock) disable iff (reset)
      (req_accept && s1_write && (s1_addr_ff == req_addr)) |=> fwd_ff)
      else $error("write-back hit not forwarded");

   // A stalled update stage keeps its request.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("stalled update stage lost its request");

   // A loaded response echoes the bin held in the update stage.
   a_rsp_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (rsp_echo_ff == $past(s1_addr_ff))))
      else $error("response echo does not match bin");

   // Only reset drops the previous column.
   a_prev_kept: assert property (@(posedge clock) disable iff (reset)
      !$fell(have_prev_ff))
      else $error("previous column lost");

endmodule

@@ test/voxel_cube_pattern_histogram_test.sv @@
// Self-checking testbench of the voxel cube pattern histogram.
`timescale 1ns / 100ps

module voxel_cube_pattern_histogram_test;
   import vcph_pkg::*;

   localparam int unsigned CountWidth   = 32;
   localparam time         ClockPeriod  = 12ns;
   localparam int unsigned RandomItems  = 1250;
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned DrainCycles  = 20;

   // One bin reading as the block should return it.
   typedef struct packed {
      logic [OutWidth-1:0] bin_count;
      bin_type             bin_echo;
   } bin_reading_type;

   logic clock = 1'b0;
   logic reset;

   vcph_req_if req_bus ();
   vcph_rsp_if rsp_bus ();

   voxel_cube_pattern_histogram #(
      .COUNT_WIDTH(CountWidth)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Own copy of the histogram and of the column history.
   logic [CountWidth-1:0] histogram_model [BinCount];
   column_type            model_column;
   logic                  model_have_column;
   bin_type               last_pattern;

   // Readings still owed by the block, oldest first.
   bin_reading_type       owed_readings [$];
   bin_reading_type       owed_head;

   int unsigned           failures;
   int unsigned           requests_sent;
   int unsigned           burst_left;
   int unsigned           hold_off_left;
   int unsigned           stall_left;
   int unsigned           stall_style;
   int unsigned           quiet_cycles;

   // Advance the histogram by one accepted request and note any reading it owes.
   function automatic void predict_request(input mode_type mode, input column_type column,
                                           input logic row_start, input bin_type bin);
      bin_reading_type reading;
      bin_type         pattern;
      case (mode)
         MODE_PUSH: begin
            pattern = {column, model_column};
            if (!row_start && model_have_column) begin
               histogram_model[pattern] = histogram_model[pattern] + 1'b1;
               last_pattern = pattern;
            end
            model_column      = column;
            model_have_column = 1'b1;
         end
         MODE_READ, MODE_CLEAR: begin
            reading.bin_count = OutWidth'(histogram_model[bin]);
            reading.bin_echo  = bin;
            owed_readings.push_back(reading);
            if (mode == MODE_CLEAR) begin
               histogram_model[bin] = '0;
            end
         end
         default: begin
            // spare mode: nothing changes
         end
      endcase
   endfunction

   // Offer one request and hold it until the block takes it; valid stays high after.
   task automatic send_request(input mode_type mode, input column_type column,
                               input logic row_start, input bin_type bin);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.column_bits <= column;
      req_bus.row_start   <= row_start;
      req_bus.bin_number  <= bin;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      predict_request(mode, column, row_start, bin);
      if (mode != MODE_SPARE) begin
         requests_sent++;
      end
   endtask

   // Send in bursts: at the end of a burst drop valid and idle before the next one.
   task automatic issue_request(input mode_type mode, input column_type column,
                                input logic row_start, input bin_type bin);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      send_request(mode, column, row_start, bin);
   endtask

   // An empty histogram reads as zero at both ends of the bin range.
   task automatic test_reset_state();
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h00);
      issue_request(MODE_CLEAR, 4'hF, 1'b1, 8'hFF);
   endtask

   // The first column after reset only becomes the history, even without row start.
   task automatic test_first_column();
      issue_request(MODE_PUSH, 4'hF, 1'b0, 8'h00);
      issue_request(MODE_PUSH, 4'h0, 1'b0, 8'hFF);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h0F);
   endtask

   // A row start counts nothing but still replaces the history.
   task automatic test_row_start();
      issue_request(MODE_PUSH, 4'hA, 1'b1, 8'h00);
      issue_request(MODE_PUSH, 4'h5, 1'b0, 8'h00);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h5A);
   endtask

   // The spare mode is swallowed: no reading, no history change.
   task automatic test_spare_mode();
      issue_request(MODE_SPARE, 4'h6, 1'b1, 8'h5A);
      issue_request(MODE_PUSH, 4'h9, 1'b0, 8'h00);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h95);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h69);
   endtask

   // Back-to-back hits on one bin, read-and-clear, and reads between pushes.
   task automatic test_read_clear();
      issue_request(MODE_PUSH, 4'hF, 1'b1, 8'h00);
      issue_request(MODE_PUSH, 4'hF, 1'b0, 8'h00);
      issue_request(MODE_PUSH, 4'hF, 1'b0, 8'h00);
      issue_request(MODE_CLEAR, 4'h0, 1'b0, 8'hFF);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'hFF);
      issue_request(MODE_PUSH, 4'hF, 1'b0, 8'h00);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'hFF);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h00);
      issue_request(MODE_PUSH, 4'h0, 1'b0, 8'h00);
      issue_request(MODE_CLEAR, 4'h0, 1'b0, 8'h0F);
      issue_request(MODE_PUSH, 4'h0, 1'b0, 8'h00);
      issue_request(MODE_READ, 4'h0, 1'b0, 8'h00);
   endtask

   // Hold the response side off while reads keep coming, so the block backs up.
   task automatic test_pressure();
      hold_off_left = 300;
      repeat (48) begin
         send_request(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_CLEAR,
                      4'($urandom), 1'($urandom), 8'($urandom));
      end
   endtask

   // Mostly whole rows with reads of freshly hit bins, plus noise and stray reads.
   task automatic test_random();
      int unsigned kind;
      int unsigned row_length;
      logic        narrow;
      column_type  column;
      mode_type    read_mode;
      while (requests_sent < RandomItems) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            narrow     = ($urandom_range(0, 1) != 0);
            row_length = $urandom_range(1, 12);
            issue_request(MODE_PUSH, 4'($urandom), 1'b1, 8'($urandom));
            repeat (row_length) begin
               column = narrow ? column_type'($urandom_range(0, 3)) : 4'($urandom);
               issue_request(MODE_PUSH, column, 1'b0, 8'($urandom));
               if ($urandom_range(0, 3) == 0) begin
                  read_mode = ($urandom_range(0, 2) == 0) ? MODE_CLEAR : MODE_READ;
                  issue_request(read_mode, 4'($urandom), 1'($urandom),
                                ($urandom_range(0, 3) != 0) ? last_pattern : 8'($urandom));
               end
            end
         end else if (kind < 85) begin
            issue_request(mode_type'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                          8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               read_mode = ($urandom_range(0, 1) != 0) ? MODE_CLEAR : MODE_READ;
               issue_request(read_mode, 4'($urandom), 1'($urandom),
                             ($urandom_range(0, 1) != 0) ? last_pattern : 8'($urandom));
            end
         end
      end
   endtask

   // Receiver: switch between random stall styles, honour hold-offs.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
         end
         stall_left--;
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_style)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Compare each accepted response with the oldest reading owed.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_readings.size() == 0) begin
            $error("response with no read outstanding: bin_echo %0d bin_count %0d",
                   rsp_bus.bin_echo, rsp_bus.bin_count);
            failures++;
         end else begin
            owed_head = owed_readings.pop_front();
            if (rsp_bus.bin_count !== owed_head.bin_count) begin
               $error("bin_count: expected %0d, got %0d", owed_head.bin_count,
                      rsp_bus.bin_count);
               failures++;
            end
            if (rsp_bus.bin_echo !== owed_head.bin_echo) begin
               $error("bin_echo: expected %0d, got %0d", owed_head.bin_echo,
                      rsp_bus.bin_echo);
               failures++;
            end
         end
      end
   end

   // Watchdog: end the run when neither side has moved anything for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < BinCount; i++) begin
         histogram_model[i] = '0;
      end
      model_column          = '0;
      model_have_column     = 1'b0;
      last_pattern          = '0;
      failures              = 0;
      requests_sent         = 0;
      burst_left            = 0;
      hold_off_left         = 0;
      stall_left            = 0;
      stall_style           = 0;
      quiet_cycles          = 0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_PUSH;
      req_bus.column_bits  <= '0;
      req_bus.row_start    <= 1'b0;
      req_bus.bin_number   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_first_column();
      test_row_start();
      test_spare_mode();
      test_read_clear();
      test_pressure();
      test_random();

      // Drop valid, drain the owed readings, then allow for stray responses.
      req_bus.valid <= 1'b0;
      while (owed_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
